// ===== rtl/core/oeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oeq_pkg
// shared constants, status codes and record types of the event queue
// ----------------------------------------------------------------------------
package oeq_pkg;

    // ring storage
    localparam int QUEUE_DEPTH = 1024;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LAP_W       = 16;
    localparam int SIZE_W      = 11;
    localparam int CNT_W       = ((IDX_W + 1) > SIZE_W) ? (IDX_W + 1) : SIZE_W;
    localparam int SIZE_RESET  = 1024;

    // result queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_LW    = $clog2(FQ_DEPTH + 2);

    // operation codes
    localparam logic OP_POST = 1'b0;
    localparam logic OP_GET  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_DROPPED   = 2'd2;
    localparam logic [1:0] ST_OVERWROTE = 2'd3;

    localparam int ATTR_W    = 58;
    localparam int PAYLOAD_W = 6 * 64;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] initiator;
        logic [7:0]  portal;
        logic [63:0] tag_bits;
        logic [63:0] requested_length;
        logic [63:0] manipulated_length;
        logic [63:0] buf_offset;
        logic [63:0] user_context;
        logic [63:0] header_data;
        logic [2:0]  failure_kind;
        logic [9:0]  atomic_code;
    } t_record;

    typedef struct packed {
        logic [1:0] status;
        t_record    rec;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

endpackage

// ===== rtl/core/oeq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oeq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module oeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/oeq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oeq_front
// accepts and classifies transactions, keeps ring indices and the event store
// ----------------------------------------------------------------------------
module oeq_front import oeq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    input  t_record           i_rec,
    input  logic [FQ_LW-1:0]  i_back_level,
    output t_push             o_push
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [SIZE_W-1:0] r_queue_size;
    logic [IDX_W-1:0]  r_p_idx, n_p_idx, r_c_idx, n_c_idx;
    logic [LAP_W-1:0]  r_p_lap, n_p_lap, r_c_lap, n_c_lap;
    logic              r_ovf, n_ovf;
    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_get, n_s1_get;
    logic [1:0]        r_s1_status, n_s1_status;

    logic [CNT_W-1:0]  size_ext, eff_size, p_next, c_next;
    logic              accept, empty, overwrote, we, re;
    logic [ATTR_W-1:0]    attr_wdata, attr_rdata;
    logic [PAYLOAD_W-1:0] pay_wdata, pay_rdata;
    t_record              rd_rec;

    assign o_ready = (i_back_level + FQ_LW'(r_s1_valid)) < FQ_LW'(FQ_DEPTH);
    assign accept  = i_valid && o_ready;

    // clamp size into 1..depth
    always_comb begin
        size_ext = CNT_W'(r_queue_size);
        if (size_ext == '0) begin
            eff_size = CNT_W'(1);
        end else if (size_ext > DEPTH_C) begin
            eff_size = DEPTH_C;
        end else begin
            eff_size = size_ext;
        end
    end

    assign p_next    = CNT_W'(r_p_idx) + CNT_W'(1);
    assign c_next    = CNT_W'(r_c_idx) + CNT_W'(1);
    assign empty     = (r_p_idx == r_c_idx) && (r_p_lap == r_c_lap);
    assign overwrote = (r_p_lap != r_c_lap) && (r_p_idx >= r_c_idx);

    always_comb begin
        n_p_idx     = r_p_idx;
        n_c_idx     = r_c_idx;
        n_p_lap     = r_p_lap;
        n_c_lap     = r_c_lap;
        n_ovf       = r_ovf;
        n_s1_valid  = accept;
        n_s1_get    = 1'b0;
        n_s1_status = ST_OK;
        we          = 1'b0;
        re          = 1'b0;
        if (accept) begin
            if (i_operation == OP_POST) begin
                we          = 1'b1;
                n_s1_status = overwrote ? ST_OVERWROTE : ST_OK;
                if (overwrote) begin
                    n_ovf = 1'b1;
                end
                if (p_next >= eff_size) begin
                    n_p_idx = '0;
                    n_p_lap = r_p_lap + LAP_W'(1);
                end else begin
                    n_p_idx = p_next[IDX_W-1:0];
                end
            end else if (empty) begin
                n_s1_status = ST_EMPTY;
            end else begin
                re          = 1'b1;
                n_s1_get    = 1'b1;
                n_s1_status = r_ovf ? ST_DROPPED : ST_OK;
                n_ovf       = 1'b0;
                if (c_next >= eff_size) begin
                    n_c_idx = '0;
                    n_c_lap = r_c_lap + LAP_W'(1);
                end else begin
                    n_c_idx = c_next[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_size <= SIZE_W'(SIZE_RESET);
            r_p_idx      <= '0;
            r_c_idx      <= '0;
            r_p_lap      <= '0;
            r_c_lap      <= '0;
            r_ovf        <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_queue_size <= i_cfg_data;
            end
            r_p_idx    <= n_p_idx;
            r_c_idx    <= n_c_idx;
            r_p_lap    <= n_p_lap;
            r_c_lap    <= n_c_lap;
            r_ovf      <= n_ovf;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_get    <= n_s1_get;
        r_s1_status <= n_s1_status;
    end

    assign attr_wdata = {i_rec.atomic_code, i_rec.failure_kind, i_rec.portal,
                         i_rec.initiator, i_rec.kind};
    assign pay_wdata  = {i_rec.header_data, i_rec.user_context, i_rec.buf_offset,
                         i_rec.manipulated_length, i_rec.requested_length,
                         i_rec.tag_bits};

    oeq_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_p_idx),
        .i_wdata (attr_wdata),
        .i_re    (re),
        .i_raddr (r_c_idx),
        .o_rdata (attr_rdata)
    );

    oeq_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_p_idx),
        .i_wdata (pay_wdata),
        .i_re    (re),
        .i_raddr (r_c_idx),
        .o_rdata (pay_rdata)
    );

    always_comb begin
        rd_rec.kind               = attr_rdata[4:0];
        rd_rec.initiator          = attr_rdata[36:5];
        rd_rec.portal             = attr_rdata[44:37];
        rd_rec.failure_kind       = attr_rdata[47:45];
        rd_rec.atomic_code        = attr_rdata[57:48];
        rd_rec.tag_bits           = pay_rdata[63:0];
        rd_rec.requested_length   = pay_rdata[127:64];
        rd_rec.manipulated_length = pay_rdata[191:128];
        rd_rec.buf_offset         = pay_rdata[255:192];
        rd_rec.user_context       = pay_rdata[319:256];
        rd_rec.header_data        = pay_rdata[383:320];
    end

    // posts and empty gets carry an all-zero record
    always_comb begin
        o_push.valid         = r_s1_valid;
        o_push.result.status = r_s1_status;
        o_push.result.rec    = r_s1_get ? rd_rec : '0;
    end

endmodule

// ===== rtl/core/oeq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oeq_back
// result queue that holds finished transactions until the consumer takes them
// ----------------------------------------------------------------------------
module oeq_back import oeq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic [FQ_LW-1:0] o_level,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_result
);

    t_result          r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FQ_LW-1:0] r_level, n_level;
    logic             pop;

    assign o_valid  = (r_level != '0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];
    assign o_level  = r_level;

    always_comb begin
        n_level = r_level;
        if (i_push.valid && !pop) begin
            n_level = r_level + FQ_LW'(1);
        end else if (!i_push.valid && pop) begin
            n_level = r_level - FQ_LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + FQ_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FQ_AW'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.result;
        end
    end

endmodule

// ===== rtl/core/overwriting_event_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_event_queue_unit
// event ring with lap counters and a sticky overflow flag, post and get
// ----------------------------------------------------------------------------
// One post or get transaction is accepted per clock cycle, sustained while
// the consumer is ready. Its result first passes through the classify step
// with its event store access (a single access to the store per cycle,
// write for a post, registered read for a get), then through the four-entry
// result queue towards the consumer. Input ready drops only
// when that queue together with the transaction in flight is full, so the
// consumer can stall without losing results. A post always writes its slot,
// even over unread events; in that case it returns status overwrote and the
// next successful get returns status dropped. Empty gets return status empty.
// Posts and empty gets carry an all-zero record. The queue size register is
// written through its own channel, which is always ready, and must only be
// written while no transaction is in flight; size 0 acts as 1 and sizes above
// the ring depth act as the depth. The store has no reset and no clearing
// pass: reading a slot that was never posted (only possible after a size
// change with events pending) returns undefined data.
// ----------------------------------------------------------------------------
module overwriting_event_queue_unit import oeq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // queue size register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    // input transactions
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    input  logic [4:0]        i_event_kind,
    input  logic [31:0]       i_initiator_id,
    input  logic [7:0]        i_portal_index,
    input  logic [63:0]       i_tag_bits,
    input  logic [63:0]       i_requested_length,
    input  logic [63:0]       i_manipulated_length,
    input  logic [63:0]       i_buf_offset,
    input  logic [63:0]       i_user_context,
    input  logic [63:0]       i_header_data,
    input  logic [2:0]        i_failure_kind,
    input  logic [9:0]        i_atomic_code,
    // result transactions
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [4:0]        o_got_kind,
    output logic [31:0]       o_got_initiator,
    output logic [7:0]        o_got_portal,
    output logic [63:0]       o_got_tag_bits,
    output logic [63:0]       o_got_requested_length,
    output logic [63:0]       o_got_manipulated_length,
    output logic [63:0]       o_got_buf_offset,
    output logic [63:0]       o_got_user_context,
    output logic [63:0]       o_got_header_data,
    output logic [2:0]        o_got_failure_kind,
    output logic [9:0]        o_got_atomic_code
);

    t_record          in_rec;
    t_push            push;
    t_result          result;
    logic [FQ_LW-1:0] back_level;

    // config register can always be written
    assign o_cfg_ready = 1'b1;

    // gather the posted record
    always_comb begin
        in_rec.kind               = i_event_kind;
        in_rec.initiator          = i_initiator_id;
        in_rec.portal             = i_portal_index;
        in_rec.tag_bits           = i_tag_bits;
        in_rec.requested_length   = i_requested_length;
        in_rec.manipulated_length = i_manipulated_length;
        in_rec.buf_offset         = i_buf_offset;
        in_rec.user_context       = i_user_context;
        in_rec.header_data        = i_header_data;
        in_rec.failure_kind       = i_failure_kind;
        in_rec.atomic_code        = i_atomic_code;
    end

    // front: classify, update indices, access the store
    oeq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_rec        (in_rec),
        .i_back_level (back_level),
        .o_push       (push)
    );

    // back: buffer results toward the consumer
    oeq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_level  (back_level),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    // scatter the result record onto the ports
    assign o_status                 = result.status;
    assign o_got_kind               = result.rec.kind;
    assign o_got_initiator          = result.rec.initiator;
    assign o_got_portal             = result.rec.portal;
    assign o_got_tag_bits           = result.rec.tag_bits;
    assign o_got_requested_length   = result.rec.requested_length;
    assign o_got_manipulated_length = result.rec.manipulated_length;
    assign o_got_buf_offset         = result.rec.buf_offset;
    assign o_got_user_context       = result.rec.user_context;
    assign o_got_header_data        = result.rec.header_data;
    assign o_got_failure_kind       = result.rec.failure_kind;
    assign o_got_atomic_code        = result.rec.atomic_code;

endmodule

// ===== rtl/core/oeq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oeq_checker
// port-level checks of the event queue, bound to the top level
// ----------------------------------------------------------------------------
module oeq_checker import oeq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [4:0]  o_got_kind,
    input logic [31:0] o_got_initiator,
    input logic [63:0] o_got_tag_bits,
    input logic [63:0] o_got_header_data
);

    logic [3:0] r_outstanding, n_outstanding;
    logic       in_acc, out_acc, zero_rec;

    assign in_acc   = i_valid && o_ready;
    assign out_acc  = o_valid && i_ready;
    assign zero_rec = (o_got_kind == '0) && (o_got_initiator == '0) &&
                      (o_got_tag_bits == '0) && (o_got_header_data == '0);

    always_comb begin
        n_outstanding = r_outstanding;
        if (in_acc && !out_acc) begin
            n_outstanding = r_outstanding + 4'd1;
        end else if (!in_acc && out_acc) begin
            n_outstanding = r_outstanding - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_got_tag_bits))
        else $error("stalled result changed");

    // no result without an accepted transaction
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_outstanding != 4'd0)
        else $error("result without pending transaction");

    // posts that overwrote carry an empty record
    a_post_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OVERWROTE |-> zero_rec)
        else $error("post result record not zero");

    // empty gets carry an empty record
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> zero_rec)
        else $error("empty result record not zero");

endmodule

bind overwriting_event_queue_unit oeq_checker u_oeq_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the overwriting event queue unit
// ----------------------------------------------------------------------------
// Post and get transactions are pushed through the valid/ready input channel
// while the result channel is stalled at random. A shadow copy of the ring
// (indices, laps, sticky overflow, slot contents) predicts every result at
// acceptance. Results are compared field by field in order. The queue size
// register is rewritten between phases, sometimes with events still pending,
// including the zero and above-depth values. Gets that would reach a slot
// never posted since reset are turned into posts.
// ----------------------------------------------------------------------------
module tb import oeq_pkg::*; ();

    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 4;   // settle margin once no result is pending
    localparam int END_CYCLES    = 10;

    // shadow copy of the ring, predicts results and compares them
    class event_ring_shadow;
        logic [SIZE_W-1:0] q_size;
        logic [IDX_W-1:0]  prod_idx;
        logic [IDX_W-1:0]  cons_idx;
        logic [LAP_W-1:0]  prod_lap;
        logic [LAP_W-1:0]  cons_lap;
        logic              overflow;
        t_record           slot_rec[QUEUE_DEPTH];
        bit                slot_written[QUEUE_DEPTH];
        t_result           awaited_results[$];
        int mismatches;
        int n_results;
        int n_posts, n_overwrote, n_gets, n_empty, n_dropped, n_cfg;

        function new();
            q_size   = SIZE_W'(SIZE_RESET);
            prod_idx = '0;
            cons_idx = '0;
            prod_lap = '0;
            cons_lap = '0;
            overflow = 1'b0;
            foreach (slot_written[i]) slot_written[i] = 1'b0;
            mismatches = 0;
            n_results  = 0;
            n_posts = 0; n_overwrote = 0; n_gets = 0;
            n_empty = 0; n_dropped = 0; n_cfg = 0;
        endfunction

        function int ring_slots();
            if (q_size == '0) return 1;
            if (int'(q_size) > QUEUE_DEPTH) return QUEUE_DEPTH;
            return int'(q_size);
        endfunction

        function void step_index(inout logic [IDX_W-1:0] idx, inout logic [LAP_W-1:0] lap);
            logic [IDX_W:0] nxt;
            nxt = {1'b0, idx} + 1'b1;
            if (int'(nxt) >= ring_slots()) begin
                nxt = '0;
                lap = lap + 1'b1;
            end
            idx = nxt[IDX_W-1:0];
        endfunction

        function void note_size(logic [SIZE_W-1:0] sz);
            q_size = sz;
            n_cfg++;
        endfunction

        // a get never touches a slot that was not posted since reset
        function bit get_reads_written();
            return (prod_idx == cons_idx && prod_lap == cons_lap) || slot_written[cons_idx];
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void note_transaction(logic op, t_record rec);
            t_result r;
            logic    over;
            r = '0;
            if (op == OP_POST) begin
                over = (prod_lap != cons_lap) && (prod_idx >= cons_idx);
                if (over) overflow = 1'b1;
                slot_rec[prod_idx]     = rec;
                slot_written[prod_idx] = 1'b1;
                step_index(prod_idx, prod_lap);
                r.status = over ? ST_OVERWROTE : ST_OK;
                n_posts++;
                if (over) n_overwrote++;
            end else if (prod_idx == cons_idx && prod_lap == cons_lap) begin
                r.status = ST_EMPTY;
                n_gets++;
                n_empty++;
            end else begin
                r.status = overflow ? ST_DROPPED : ST_OK;
                if (overflow) n_dropped++;
                overflow = 1'b0;
                r.rec = slot_rec[cons_idx];
                step_index(cons_idx, cons_lap);
                n_gets++;
            end
            awaited_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch at result %0d: %s", $time, n_results, msg);
            mismatches++;
        endtask

        task compare_field(string fname, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", fname, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result arrived with nothing pending");
            end else begin
                want = awaited_results.pop_front();
                compare_field("status", 64'(got.status), 64'(want.status));
                compare_field("kind", 64'(got.rec.kind), 64'(want.rec.kind));
                compare_field("initiator", 64'(got.rec.initiator), 64'(want.rec.initiator));
                compare_field("portal", 64'(got.rec.portal), 64'(want.rec.portal));
                compare_field("tag_bits", got.rec.tag_bits, want.rec.tag_bits);
                compare_field("requested_length", got.rec.requested_length,
                              want.rec.requested_length);
                compare_field("manipulated_length", got.rec.manipulated_length,
                              want.rec.manipulated_length);
                compare_field("buf_offset", got.rec.buf_offset, want.rec.buf_offset);
                compare_field("user_context", got.rec.user_context, want.rec.user_context);
                compare_field("header_data", got.rec.header_data, want.rec.header_data);
                compare_field("failure_kind", 64'(got.rec.failure_kind),
                              64'(want.rec.failure_kind));
                compare_field("atomic_code", 64'(got.rec.atomic_code),
                              64'(want.rec.atomic_code));
            end
            n_results++;
        endtask
    endclass

    // dut signals
    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic              i_operation;
    logic [4:0]        i_event_kind;
    logic [31:0]       i_initiator_id;
    logic [7:0]        i_portal_index;
    logic [63:0]       i_tag_bits;
    logic [63:0]       i_requested_length;
    logic [63:0]       i_manipulated_length;
    logic [63:0]       i_buf_offset;
    logic [63:0]       i_user_context;
    logic [63:0]       i_header_data;
    logic [2:0]        i_failure_kind;
    logic [9:0]        i_atomic_code;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_status;
    logic [4:0]        o_got_kind;
    logic [31:0]       o_got_initiator;
    logic [7:0]        o_got_portal;
    logic [63:0]       o_got_tag_bits;
    logic [63:0]       o_got_requested_length;
    logic [63:0]       o_got_manipulated_length;
    logic [63:0]       o_got_buf_offset;
    logic [63:0]       o_got_user_context;
    logic [63:0]       o_got_header_data;
    logic [2:0]        o_got_failure_kind;
    logic [9:0]        o_got_atomic_code;

    event_ring_shadow ring;
    bit               no_idle;   // phase without gaps or stalls on either side

    overwriting_event_queue_unit dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_data               (i_cfg_data),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_operation              (i_operation),
        .i_event_kind             (i_event_kind),
        .i_initiator_id           (i_initiator_id),
        .i_portal_index           (i_portal_index),
        .i_tag_bits               (i_tag_bits),
        .i_requested_length       (i_requested_length),
        .i_manipulated_length     (i_manipulated_length),
        .i_buf_offset             (i_buf_offset),
        .i_user_context           (i_user_context),
        .i_header_data            (i_header_data),
        .i_failure_kind           (i_failure_kind),
        .i_atomic_code            (i_atomic_code),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_status                 (o_status),
        .o_got_kind               (o_got_kind),
        .o_got_initiator          (o_got_initiator),
        .o_got_portal             (o_got_portal),
        .o_got_tag_bits           (o_got_tag_bits),
        .o_got_requested_length   (o_got_requested_length),
        .o_got_manipulated_length (o_got_manipulated_length),
        .o_got_buf_offset         (o_got_buf_offset),
        .o_got_user_context       (o_got_user_context),
        .o_got_header_data        (o_got_header_data),
        .o_got_failure_kind       (o_got_failure_kind),
        .o_got_atomic_code        (o_got_atomic_code)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #5_000_000;
        $display("timeout with %0d results still pending", ring.outstanding());
        $display("CHECKS FAILED");
        $finish;
    end

    // edge-biased word: all zeros, all ones or random
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_record rand_record();
        t_record     rec;
        logic [63:0] w;
        w = rand_word(); rec.kind         = w[4:0];
        w = rand_word(); rec.initiator    = w[31:0];
        w = rand_word(); rec.portal       = w[7:0];
        w = rand_word(); rec.failure_kind = w[2:0];
        w = rand_word(); rec.atomic_code  = w[9:0];
        rec.tag_bits           = rand_word();
        rec.requested_length   = rand_word();
        rec.manipulated_length = rand_word();
        rec.buf_offset         = rand_word();
        rec.user_context       = rand_word();
        rec.header_data        = rand_word();
        return rec;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return SIZE_W'(1);
            1: return SIZE_W'(2);
            2: return SIZE_W'(3);
            3: return SIZE_W'($urandom_range(4, 16));
            4: return SIZE_W'($urandom_range(17, 64));
            5: return '0;
            6: return SIZE_W'(QUEUE_DEPTH);
            7: return SIZE_W'($urandom_range(QUEUE_DEPTH + 1, 2047));
            8: return SIZE_W'($urandom_range(1, QUEUE_DEPTH - 1));
            default: return SIZE_W'(5);
        endcase
    endfunction

    // one input transaction, entered and left at a falling edge;
    // valid stays high on exit so back-to-back items need no drop
    task automatic drive_event(input logic op, input t_record rec);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        // never let a get reach a slot that holds nothing yet
        if (op == OP_GET && !ring.get_reads_written()) op = OP_POST;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid              <= 1'b1;
        i_operation          <= op;
        i_event_kind         <= rec.kind;
        i_initiator_id       <= rec.initiator;
        i_portal_index       <= rec.portal;
        i_tag_bits           <= rec.tag_bits;
        i_requested_length   <= rec.requested_length;
        i_manipulated_length <= rec.manipulated_length;
        i_buf_offset         <= rec.buf_offset;
        i_user_context       <= rec.user_context;
        i_header_data        <= rec.header_data;
        i_failure_kind       <= rec.failure_kind;
        i_atomic_code        <= rec.atomic_code;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // stop issuing, wait for every pending result, then let the pipe empty
    task automatic settle_ring();
        i_valid <= 1'b0;
        while (ring.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // queue size register write, only called on an idle block
    task automatic write_queue_size(input logic [SIZE_W-1:0] sz);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stall before each result transaction
    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // transaction monitor: predict on acceptance, check on delivery
    always @(posedge i_clk) begin : observe
        t_record rec_in;
        t_result seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ring.note_size(i_cfg_data);
            if (i_valid && o_ready) begin
                rec_in.kind               = i_event_kind;
                rec_in.initiator          = i_initiator_id;
                rec_in.portal             = i_portal_index;
                rec_in.tag_bits           = i_tag_bits;
                rec_in.requested_length   = i_requested_length;
                rec_in.manipulated_length = i_manipulated_length;
                rec_in.buf_offset         = i_buf_offset;
                rec_in.user_context       = i_user_context;
                rec_in.header_data        = i_header_data;
                rec_in.failure_kind       = i_failure_kind;
                rec_in.atomic_code        = i_atomic_code;
                ring.note_transaction(i_operation, rec_in);
            end
            if (o_valid && i_ready) begin
                seen.status                 = o_status;
                seen.rec.kind               = o_got_kind;
                seen.rec.initiator          = o_got_initiator;
                seen.rec.portal             = o_got_portal;
                seen.rec.tag_bits           = o_got_tag_bits;
                seen.rec.requested_length   = o_got_requested_length;
                seen.rec.manipulated_length = o_got_manipulated_length;
                seen.rec.buf_offset         = o_got_buf_offset;
                seen.rec.user_context       = o_got_user_context;
                seen.rec.header_data        = o_got_header_data;
                seen.rec.failure_kind       = o_got_failure_kind;
                seen.rec.atomic_code        = o_got_atomic_code;
                ring.check_result(seen);
            end
        end
    end

    initial begin : stimulus
        int sent;
        int phase_len;
        int post_pct;
        int k;
        logic op;

        ring    = new();
        no_idle = 1'b0;

        // every input known from time zero
        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_data           = '0;
        i_valid              = 1'b0;
        i_operation          = OP_POST;
        i_event_kind         = '0;
        i_initiator_id       = '0;
        i_portal_index       = '0;
        i_tag_bits           = '0;
        i_requested_length   = '0;
        i_manipulated_length = '0;
        i_buf_offset         = '0;
        i_user_context       = '0;
        i_header_data        = '0;
        i_failure_kind       = '0;
        i_atomic_code        = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // get on an empty ring, then all-ones and all-zeros records round trip
        drive_event(OP_GET, rand_record());
        drive_event(OP_POST, '1);
        drive_event(OP_POST, '0);
        drive_event(OP_GET, rand_record());
        drive_event(OP_GET, rand_record());

        // two slots, entered with both indices at slot 2: the posts wrap without
        // lapping, the gets return all three in order and the fourth runs empty
        settle_ring();
        write_queue_size(SIZE_W'(2));
        repeat (3) drive_event(OP_POST, rand_record());
        repeat (4) drive_event(OP_GET, rand_record());

        // size zero behaves as a single slot
        settle_ring();
        write_queue_size('0);
        drive_event(OP_POST, rand_record());
        drive_event(OP_POST, rand_record());
        drive_event(OP_GET, rand_record());

        // size above the ring depth is clipped to the depth
        settle_ring();
        write_queue_size('1);
        drive_event(OP_POST, rand_record());
        drive_event(OP_GET, rand_record());

        // shrink the ring while events are still pending
        settle_ring();
        write_queue_size(SIZE_W'(8));
        repeat (5) drive_event(OP_POST, rand_record());
        settle_ring();
        write_queue_size(SIZE_W'(3));
        repeat (3) drive_event(OP_GET, rand_record());
        drive_event(OP_POST, rand_record());

        // random phases: each with its own size, post/get mix and idling mode
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_ring();
            write_queue_size(pick_size());
            phase_len = $urandom_range(20, 120);
            if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
            case ($urandom_range(0, 3))
                0: post_pct = 15;
                1: post_pct = 50;
                2: post_pct = 65;
                default: post_pct = 90;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < phase_len; k++) begin
                op = ($urandom_range(0, 99) < post_pct) ? OP_POST : OP_GET;
                drive_event(op, rand_record());
            end
            sent += phase_len;
        end

        // drain and give the pipe time to show any stray result
        no_idle = 1'b0;
        settle_ring();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("run covered %0d posts (%0d overwrote) and %0d gets (%0d empty, %0d dropped)",
                 ring.n_posts, ring.n_overwrote, ring.n_gets, ring.n_empty, ring.n_dropped);
        $display("across %0d queue size writes, %0d results compared",
                 ring.n_cfg, ring.n_results);
        if (ring.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
